// File: sv/rrts_pkg.sv
package rrts_pkg;

	// Default pool size and slice length after reset
	localparam int TASK_SLOTS_DEF = 16;
	localparam int SLICE_W = 16;
	localparam logic [SLICE_W-1:0] TIME_SLICE_RESET = 16'd10;

	// Operation codes of a command beat
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CREATE = 2'd1;
	localparam logic [1:0] OP_YIELD = 2'd2;
	localparam logic [1:0] OP_EXIT = 2'd3;

	// Slot status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_READY = 2'd0;
	localparam status_t ST_RUNNING = 2'd1;
	localparam status_t ST_TERMINATED = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic user_level;
	} item_t;

	typedef struct packed {
		logic [31:0] created_id;
		logic [3:0] created_slot;
		logic switched;
		logic [3:0] from_slot;
		logic [3:0] to_slot;
		logic to_is_user;
		logic [31:0] to_run_count;
		logic has_current;
		logic [3:0] current_slot;
	} result_t;

endpackage

// File: sv/round_robin_time_slice_scheduler.sv
// Round-robin task scheduler over TASK_SLOTS slots. A command beat is taken at every clock edge
// with start high (busy is never raised), and its result appears on the following cycle with done
// high for exactly that one cycle; the receiver cannot stall, so it must take each result when
// done is seen. One command is processed per clock: the lowest-free-slot search, the ready queue
// push and pop and the slot table update all sit in one combinational pass ahead of the result
// register. Write the slice length through cfg_wr_en/cfg_wr_data only while no command is in
// flight; a value of zero makes every tick a reschedule.
module round_robin_time_slice_scheduler #(
	parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [rrts_pkg::SLICE_W-1:0] cfg_wr_data,
	input logic start,
	input rrts_pkg::item_t item,
	output logic busy,
	output logic done,
	output rrts_pkg::result_t result
);
	import rrts_pkg::*;

	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TASK_SLOTS);

	// Scheduler state
	logic [SLICE_W-1:0] time_slice_q;
	status_t slot_status_q [TASK_SLOTS];
	logic slot_user_q [TASK_SLOTS];
	logic [31:0] slot_runs_q [TASK_SLOTS];
	logic [SLOT_W-1:0] ready_fifo_q [TASK_SLOTS];
	logic [SLOT_W-1:0] fifo_head_q;
	logic [SLOT_W-1:0] fifo_tail_q;
	logic [CNT_W-1:0] fifo_count_q;
	logic [SLOT_W-1:0] running_slot_q;
	logic running_valid_q;
	logic [SLICE_W-1:0] slice_left_q;
	logic [31:0] id_counter_q;
	logic done_q;
	result_t result_q;

	// Next-state values
	status_t status_d [TASK_SLOTS];
	logic [SLOT_W-1:0] head_d;
	logic [SLOT_W-1:0] tail_d;
	logic [CNT_W-1:0] count_d;
	logic [SLOT_W-1:0] running_slot_d;
	logic running_valid_d;
	logic [SLICE_W-1:0] slice_d;
	logic [31:0] id_d;
	result_t res_d;

	logic free_found;
	logic [SLOT_W-1:0] free_slot;
	logic push_en;
	logic push_ok;
	logic [SLOT_W-1:0] push_slot;
	logic pop_en;
	logic [SLOT_W-1:0] nxt_slot;
	logic runs_we;
	logic [SLOT_W-1:0] runs_wa;
	logic [31:0] runs_wd;
	logic user_we;

	assign busy = 1'b0;
	assign done = done_q;
	assign result = result_q;

	// Find the lowest terminated slot
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int k = TASK_SLOTS - 1; k >= 0; k--) begin
			if (slot_status_q[k] == ST_TERMINATED) begin
				free_found = 1'b1;
				free_slot = SLOT_W'(k);
			end
		end
	end

	// Work out the effect of one command beat
	always_comb begin
		status_t cur_st;
		logic cur_run;
		logic do_sched;
		logic [SLICE_W-1:0] slice_in;
		logic [SLICE_W-1:0] slice_dec;

		status_d = slot_status_q;
		running_slot_d = running_slot_q;
		running_valid_d = running_valid_q;
		slice_d = slice_left_q;
		id_d = id_counter_q;
		res_d = '0;
		push_en = 1'b0;
		push_slot = running_slot_q;
		pop_en = 1'b0;
		nxt_slot = ready_fifo_q[fifo_head_q];
		runs_we = 1'b0;
		runs_wa = free_slot;
		runs_wd = '0;
		user_we = 1'b0;
		do_sched = 1'b0;
		cur_st = slot_status_q[running_slot_q];
		cur_run = 1'b0;
		slice_in = slice_left_q;
		slice_dec = '0;

		case (item.operation)
			OP_TICK: begin
				do_sched = running_valid_q;
			end
			OP_CREATE: begin
				if (free_found) begin
					res_d.created_id = id_counter_q;
					res_d.created_slot = 4'(free_slot);
					id_d = id_counter_q + 32'd1;
					user_we = 1'b1;
					runs_we = 1'b1;
					if (!running_valid_q) begin
						status_d[free_slot] = ST_RUNNING;
						running_slot_d = free_slot;
						running_valid_d = 1'b1;
						slice_d = time_slice_q;
					end else begin
						status_d[free_slot] = ST_READY;
						push_en = 1'b1;
						push_slot = free_slot;
					end
				end
			end
			OP_YIELD: begin
				if (running_valid_q) begin
					slice_d = '0;
				end
			end
			OP_EXIT: begin
				if (running_valid_q) begin
					status_d[running_slot_q] = ST_TERMINATED;
					cur_st = ST_TERMINATED;
					slice_in = '0;
					do_sched = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Count the slice down; requeue and switch when it runs out, and switch also when the current task has terminated
		if (do_sched) begin
			cur_run = (cur_st == ST_RUNNING);
			slice_dec = (slice_in != '0) ? slice_in - SLICE_W'(1) : '0;
			slice_d = slice_dec;
			if (slice_dec == '0 || !cur_run) begin
				if (cur_run) begin
					status_d[running_slot_q] = ST_READY;
					slice_d = time_slice_q;
					push_en = 1'b1;
					push_slot = running_slot_q;
				end
				if (cur_run || fifo_count_q != '0) begin
					pop_en = 1'b1;
					// an empty queue hands back the slot pushed in this beat
					nxt_slot = (fifo_count_q == '0) ? running_slot_q
						: ready_fifo_q[fifo_head_q];
					status_d[nxt_slot] = ST_RUNNING;
					slice_d = time_slice_q;
					runs_we = 1'b1;
					runs_wa = nxt_slot;
					runs_wd = slot_runs_q[nxt_slot] + 32'd1;
					res_d.switched = 1'b1;
					res_d.from_slot = 4'(running_slot_q);
					res_d.to_slot = 4'(nxt_slot);
					res_d.to_is_user = slot_user_q[nxt_slot];
					res_d.to_run_count = runs_wd;
					running_slot_d = nxt_slot;
				end
			end
		end

		res_d.has_current = running_valid_d;
		res_d.current_slot = 4'(running_slot_d);
	end

	// Advance the queue pointers; drop a push into a full queue
	always_comb begin
		push_ok = push_en && (fifo_count_q != FULL_CNT);
		tail_d = fifo_tail_q;
		head_d = fifo_head_q;
		if (push_ok) begin
			tail_d = (fifo_tail_q == LAST_SLOT) ? '0 : fifo_tail_q + SLOT_W'(1);
		end
		if (pop_en) begin
			head_d = (fifo_head_q == LAST_SLOT) ? '0 : fifo_head_q + SLOT_W'(1);
		end
		count_d = fifo_count_q + CNT_W'(push_ok) - CNT_W'(pop_en);
	end

	// Control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_slice_q <= TIME_SLICE_RESET;
			for (int k = 0; k < TASK_SLOTS; k++) begin
				slot_status_q[k] <= ST_TERMINATED;
			end
			fifo_head_q <= '0;
			fifo_tail_q <= '0;
			fifo_count_q <= '0;
			running_slot_q <= '0;
			running_valid_q <= 1'b0;
			slice_left_q <= '0;
			id_counter_q <= 32'd1;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				time_slice_q <= cfg_wr_data;
			end
			done_q <= start;
			if (start) begin
				slot_status_q <= status_d;
				fifo_head_q <= head_d;
				fifo_tail_q <= tail_d;
				fifo_count_q <= count_d;
				running_slot_q <= running_slot_d;
				running_valid_q <= running_valid_d;
				slice_left_q <= slice_d;
				id_counter_q <= id_d;
			end
		end
	end

	// Slot tables, ready queue and result register
	always_ff @(posedge clk) begin
		if (start) begin
			if (runs_we) begin
				slot_runs_q[runs_wa] <= runs_wd;
			end
			if (user_we) begin
				slot_user_q[free_slot] <= item.user_level;
			end
			if (push_ok) begin
				ready_fifo_q[fifo_tail_q] <= push_slot;
			end
			result_q <= res_d;
		end
	end

	// Each command beat gives exactly one result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) start |=> done_q)
		else $error("command beat without result");
	assert property (@(posedge clk) disable iff (!arst_n) !start |=> !done_q)
		else $error("result without command beat");

	// Queue bookkeeping stays consistent
	assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count_q <= FULL_CNT) && ((fifo_count_q != '0) || (fifo_head_q == fifo_tail_q)))
		else $error("ready queue count out of step with pointers");

	// A switch lands on the reported slot
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.switched |-> result_q.has_current
			&& (result_q.current_slot == result_q.to_slot))
		else $error("switch result disagrees with current slot");

	// Once a current task exists it is never lost
	assert property (@(posedge clk) disable iff (!arst_n) running_valid_q |=> running_valid_q)
		else $error("current task lost");

endmodule

// File: test/round_robin_time_slice_scheduler_test.sv
`timescale 1ns / 100ps

module round_robin_time_slice_scheduler_test;
	import rrts_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;

	// Scheduler shadow: mirrors slot table, ready ring and slice counter
	class sched_tracker;
		status_t slot_state [SLOTS];
		logic slot_is_user [SLOTS];
		logic [31:0] slot_run_cnt [SLOTS];
		logic [3:0] ready_ring [SLOTS];
		int unsigned ring_head, ring_tail, ring_fill;
		logic [3:0] cur_slot;
		logic cur_valid;
		logic [SLICE_W-1:0] ticks_left;
		logic [SLICE_W-1:0] slice_len;
		logic [31:0] next_id;
		result_t outcome;
		result_t due_results [$];
		int unsigned fails;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_state[i] = ST_TERMINATED;
				slot_is_user[i] = 1'b0;
				slot_run_cnt[i] = '0;
				ready_ring[i] = '0;
			end
			ring_head = 0;
			ring_tail = 0;
			ring_fill = 0;
			cur_slot = '0;
			cur_valid = 1'b0;
			ticks_left = '0;
			slice_len = TIME_SLICE_RESET;
			next_id = 32'd1;
			fails = 0;
		endfunction

		function void set_slice(logic [SLICE_W-1:0] v);
			slice_len = v;
		endfunction

		// Append to the ready ring; drop when full
		function void ring_push(logic [3:0] s);
			if (ring_fill >= SLOTS)
				return;
			ready_ring[ring_tail] = s;
			ring_tail = (ring_tail + 1) % SLOTS;
			ring_fill++;
		endfunction

		// Count the slice down and hand over to the ring head when due
		function void rotate();
			logic [3:0] prev;
			logic [3:0] nxt;
			if (!cur_valid)
				return;
			prev = cur_slot;
			if (ticks_left != 0)
				ticks_left--;
			if (ticks_left != 0 && slot_state[prev] == ST_RUNNING)
				return;
			if (slot_state[prev] == ST_RUNNING) begin
				slot_state[prev] = ST_READY;
				ticks_left = slice_len;
				ring_push(prev);
			end
			if (ring_fill == 0)
				return;
			nxt = ready_ring[ring_head];
			ring_head = (ring_head + 1) % SLOTS;
			ring_fill--;
			slot_state[nxt] = ST_RUNNING;
			ticks_left = slice_len;
			slot_run_cnt[nxt] = slot_run_cnt[nxt] + 32'd1;
			outcome.switched = 1'b1;
			outcome.from_slot = prev;
			outcome.to_slot = nxt;
			outcome.to_is_user = slot_is_user[nxt];
			outcome.to_run_count = slot_run_cnt[nxt];
			cur_slot = nxt;
		endfunction

		// Apply one accepted command beat and queue the result it must give
		function void note_command(item_t it);
			int free_idx;
			outcome = '0;
			free_idx = -1;
			case (it.operation)
				OP_TICK: rotate();
				OP_CREATE: begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (slot_state[i] == ST_TERMINATED)
							free_idx = i;
					if (free_idx >= 0) begin
						outcome.created_id = next_id;
						outcome.created_slot = free_idx[3:0];
						next_id = next_id + 32'd1;
						slot_is_user[free_idx] = it.user_level;
						slot_run_cnt[free_idx] = '0;
						if (!cur_valid) begin
							slot_state[free_idx] = ST_RUNNING;
							cur_slot = free_idx[3:0];
							cur_valid = 1'b1;
							ticks_left = slice_len;
						end else begin
							slot_state[free_idx] = ST_READY;
							ring_push(free_idx[3:0]);
						end
					end
				end
				OP_YIELD: begin
					if (cur_valid)
						ticks_left = '0;
				end
				OP_EXIT: begin
					if (cur_valid) begin
						slot_state[cur_slot] = ST_TERMINATED;
						ticks_left = '0;
						rotate();
					end
				end
			endcase
			outcome.has_current = cur_valid;
			outcome.current_slot = cur_slot;
			due_results.push_back(outcome);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		// Compare a result beat with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result beat with no command outstanding");
				fails++;
				return;
			end
			want = due_results.pop_front();
			check_field("created_id", want.created_id, got.created_id);
			check_field("created_slot", 32'(want.created_slot), 32'(got.created_slot));
			check_field("switched", 32'(want.switched), 32'(got.switched));
			check_field("from_slot", 32'(want.from_slot), 32'(got.from_slot));
			check_field("to_slot", 32'(want.to_slot), 32'(got.to_slot));
			check_field("to_is_user", 32'(want.to_is_user), 32'(got.to_is_user));
			check_field("to_run_count", want.to_run_count, got.to_run_count);
			check_field("has_current", 32'(want.has_current), 32'(got.has_current));
			check_field("current_slot", 32'(want.current_slot), 32'(got.current_slot));
		endfunction

		function void close_out();
			if (due_results.size() != 0) begin
				$error("%0d results never arrived", due_results.size());
				fails += due_results.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [SLICE_W-1:0] cfg_wr_data;
	logic start;
	item_t item;
	logic busy;
	logic done;
	result_t result;

	sched_tracker sb = new();

	round_robin_time_slice_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Check every result beat on the edge that takes it
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic item_t cmd(logic [1:0] op, logic user);
		item_t it;
		it.operation = op;
		it.user_level = user;
		return it;
	endfunction

	// Draw an operation; mix 1 leans towards filling the pool, mix 2 and up towards draining it, mix 0 lies between
	function automatic item_t rand_command(int unsigned mix);
		int unsigned pick;
		logic [1:0] op;
		pick = $urandom_range(99);
		case (mix)
			0: op = pick < 45 ? OP_TICK : pick < 65 ? OP_CREATE : pick < 80 ? OP_YIELD : OP_EXIT;
			1: op = pick < 25 ? OP_TICK : pick < 85 ? OP_CREATE : pick < 90 ? OP_YIELD : OP_EXIT;
			default: op = pick < 30 ? OP_TICK : pick < 45 ? OP_CREATE : pick < 55 ? OP_YIELD
				: OP_EXIT;
		endcase
		return cmd(op, 1'($urandom_range(1)));
	endfunction

	// Offer one command beat, idling first at random, and hold it until taken
	task automatic send_command(item_t it, int unsigned idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (busy);
		sb.note_command(it);
	endtask

	// Lower start and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_slice(logic [SLICE_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_slice(v);
	endtask

	initial begin
		logic [SLICE_W-1:0] slices [6];
		int unsigned idle_pcts [3];
		int unsigned mix;
		int waited;
		slices = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd2, 16'd10};
		idle_pcts = '{0, 75, 6};
		mix = 0;
		waited = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		start = 1'b0;
		item = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Opening sequence at the reset slice length
		send_command(cmd(OP_TICK, 1'b0), 0);
		send_command(cmd(OP_YIELD, 1'b1), 0);
		send_command(cmd(OP_EXIT, 1'b0), 0);
		send_command(cmd(OP_CREATE, 1'b1), 0);
		send_command(cmd(OP_CREATE, 1'b0), 0);
		send_command(cmd(OP_YIELD, 1'b0), 0);
		send_command(cmd(OP_TICK, 1'b0), 0);
		// exit with a task queued, then with none left
		send_command(cmd(OP_EXIT, 1'b1), 0);
		send_command(cmd(OP_EXIT, 1'b0), 0);
		send_command(cmd(OP_TICK, 1'b1), 0);
		// reuse the terminated current slot while it is still current
		send_command(cmd(OP_CREATE, 1'b1), 0);
		send_command(cmd(OP_TICK, 1'b0), 0);
		// lone task at expiry switches to itself
		send_command(cmd(OP_YIELD, 1'b1), 0);
		send_command(cmd(OP_TICK, 1'b0), 0);
		send_command(cmd(OP_CREATE, 1'b0), 0);
		send_command(cmd(OP_CREATE, 1'b1), 0);
		settle();

		// Random phases, each at its own slice length, with the idling rate taken in turn from three values
		for (int p = 0; p < 6; p++) begin
			write_slice(slices[p]);
			for (int n = 0; n < 250; n++) begin
				if (n % 40 == 0)
					mix = $urandom_range(2);
				send_command(rand_command(mix), idle_pcts[p % 3]);
			end
			settle();
		end

		// Drain with a bound, then let the block idle before closing out
		while (sb.due_results.size() != 0 && waited < 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);
		sb.close_out();
		if (sb.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/rrts_pkg.sv
sv/round_robin_time_slice_scheduler.sv
test/round_robin_time_slice_scheduler_test.sv
